// File: src/mandelbrot_orbit_trap_point_macros.svh
// ----------------------------------------------------------------------------
// Mandelbrot orbit trap point - assertion macros
// Concurrent assertion helpers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_ORBIT_TRAP_POINT_MACROS_SVH
`define MANDELBROT_ORBIT_TRAP_POINT_MACROS_SVH

`ifndef SYNTH
`define MOTP_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define MOTP_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define MOTP_ASSERT_IMP(name, clk, rst, ante, cons)
`define MOTP_ASSERT_NXT(name, clk, rst, ante, cons)
`endif

`endif

// File: src/motp_pkg.sv
// ----------------------------------------------------------------------------
// Mandelbrot orbit trap point - package
// Widths, fixed-point constants and the sequencer state type.
// ----------------------------------------------------------------------------
package motp_pkg;

   localparam int COORD_W    = 32;
   localparam int FRAC_BITS  = 28;
   localparam int PROD_W     = 2 * COORD_W;
   localparam int SQ_W       = PROD_W - FRAC_BITS;   // scaled product
   localparam int MAG_W      = SQ_W + 1;
   localparam int ACC_W      = SQ_W + 2;
   localparam int CNT_W      = 13;
   localparam int RAD_W      = 28;

   localparam logic [CNT_W-1:0] ITER_LIMIT = CNT_W'(4096);
   localparam logic [CNT_W-1:0] MIN_ITERS  = CNT_W'(32);
   localparam logic [CNT_W-1:0] ITER_RESET = CNT_W'(32);

   localparam logic signed [MAG_W-1:0] MAG_ONE  = MAG_W'(1) << FRAC_BITS;
   localparam logic signed [MAG_W-1:0] MAG_FOUR = MAG_W'(4) << FRAC_BITS;

   localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sd2147483647);
   localparam logic signed [ACC_W-1:0] SAT_LO = -(ACC_W'(64'sd2147483648));

   localparam int REQ_DATA_W = 2 * COORD_W;
   localparam int RSP_DATA_W = 112;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQ_RE,
      ST_SQ_IM,
      ST_CROSS,
      ST_UPDATE,
      ST_FINISH
   } state_type;

endpackage

// File: src/motp_mul.sv
// ----------------------------------------------------------------------------
// Mandelbrot orbit trap point - shared multiplier
// Registered signed 32x32 product, rescaled by floor shift of FRAC_BITS.
// ----------------------------------------------------------------------------
module motp_mul (
   input  logic                                 clock,
   input  logic signed [motp_pkg::COORD_W-1:0]  op_a,
   input  logic signed [motp_pkg::COORD_W-1:0]  op_b,
   output logic signed [motp_pkg::SQ_W-1:0]     prod_q
);
   import motp_pkg::*;

   logic signed [PROD_W-1:0] product;
   logic signed [SQ_W-1:0]   prod_ff;
   logic signed [SQ_W-1:0]   prod_in;

   assign product = PROD_W'(op_a) * PROD_W'(op_b);
   assign prod_in = product[PROD_W-1:FRAC_BITS];

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod_q = prod_ff;

endmodule

// File: src/mandelbrot_orbit_trap_point.sv
// ----------------------------------------------------------------------------
// Mandelbrot orbit trap point
// Escape-time iteration of one Q4.28 point with a unit-circle orbit trap.
// ----------------------------------------------------------------------------
// One point is taken when req_tready is high; the block then works on it
// alone. Each iteration uses the single registered 32x32 multiplier three
// times (re^2, im^2, re*im) and then updates z, stepping through ST_SQ_RE,
// ST_SQ_IM, ST_CROSS and ST_UPDATE. It runs n iterations (escape_count + 1
// on escape, else the clamped bound of 32..4096); rsp_tvalid rises and
// req_tready returns in the same cycle, so no new point is taken while
// one is in work. A finished word waits in the output register while the
// next point is accepted; a newer result is held until that register
// frees up. csr_wr_data writes the iteration cap (clamped to 32..4096
// when used).
// ----------------------------------------------------------------------------
`include "mandelbrot_orbit_trap_point_macros.svh"

module mandelbrot_orbit_trap_point (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [motp_pkg::CNT_W-1:0]            csr_wr_data,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // point_re [31:0], point_im [63:32]
   input  logic [motp_pkg::REQ_DATA_W-1:0]       req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // escape_count [12:0], trap_radius_sq [40:13], trap_re [72:41],
   // trap_im [104:73], zero [111:105]
   output logic [motp_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   // trapped [0]
   output logic                                  rsp_tuser
);
   import motp_pkg::*;

   state_type state_ff, state_in;

   logic [CNT_W-1:0]          iter_cap_ff;
   logic [CNT_W-1:0]          bound;
   logic [CNT_W-1:0]          iter_ff;

   logic signed [COORD_W-1:0] cr_ff, ci_ff, zr_ff, zi_ff;
   logic signed [SQ_W-1:0]    rsq_ff, isq_ff;
   logic                      hit_ff;
   logic [RAD_W-1:0]          rad_ff;
   logic signed [COORD_W-1:0] tre_ff, tim_ff;

   logic                      out_valid_ff;
   logic [CNT_W-1:0]          out_count_ff;
   logic                      out_hit_ff;
   logic [RAD_W-1:0]          out_rad_ff;
   logic signed [COORD_W-1:0] out_re_ff, out_im_ff;

   logic signed [COORD_W-1:0] mul_a, mul_b;
   logic signed [SQ_W-1:0]    mul_q;

   logic signed [MAG_W-1:0]   mag;
   logic signed [ACC_W-1:0]   re_sum, im_sum;
   logic signed [COORD_W-1:0] zr_new, zi_new;
   logic                      trap_now, escape_now, last_iter;
   logic                      req_fire, out_free;

   motp_mul u_mul (
      .clock  (clock),
      .op_a   (mul_a),
      .op_b   (mul_b),
      .prod_q (mul_q)
   );

   always_comb begin
      priority if (iter_cap_ff > ITER_LIMIT) begin
         bound = ITER_LIMIT;
      end else if (iter_cap_ff < MIN_ITERS) begin
         bound = MIN_ITERS;
      end else begin
         bound = iter_cap_ff;
      end
   end

   // update datapath: mul_q holds the cross product in ST_UPDATE
   assign mag    = MAG_W'(rsq_ff) + MAG_W'(isq_ff);
   assign re_sum = ACC_W'(rsq_ff) - ACC_W'(isq_ff) + ACC_W'(cr_ff);
   assign im_sum = ACC_W'(mul_q) + ACC_W'(mul_q) + ACC_W'(ci_ff);

   always_comb begin
      priority if (re_sum > SAT_HI) begin
         zr_new = SAT_HI[COORD_W-1:0];
      end else if (re_sum < SAT_LO) begin
         zr_new = SAT_LO[COORD_W-1:0];
      end else begin
         zr_new = re_sum[COORD_W-1:0];
      end
      priority if (im_sum > SAT_HI) begin
         zi_new = SAT_HI[COORD_W-1:0];
      end else if (im_sum < SAT_LO) begin
         zi_new = SAT_LO[COORD_W-1:0];
      end else begin
         zi_new = im_sum[COORD_W-1:0];
      end
   end

   assign trap_now   = mag < MAG_ONE;
   assign escape_now = !trap_now && (mag > MAG_FOUR);
   assign last_iter  = (iter_ff + CNT_W'(1)) == bound;
   assign out_free   = !out_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_SQ_RE;
            end
         end
         ST_SQ_RE:  state_in = ST_SQ_IM;
         ST_SQ_IM:  state_in = ST_CROSS;
         ST_CROSS:  state_in = ST_UPDATE;
         ST_UPDATE: begin
            if (escape_now || last_iter) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_SQ_RE;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_tready = 1'b0;
      mul_a      = zr_ff;
      mul_b      = zr_ff;
      unique case (state_ff)
         ST_IDLE:  req_tready = 1'b1;
         ST_SQ_IM: begin
            mul_a = zi_ff;
            mul_b = zi_ff;
         end
         ST_CROSS: begin
            mul_a = zr_ff;
            mul_b = zi_ff;
         end
         default: begin
            mul_a = zr_ff;
            mul_b = zr_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         iter_cap_ff  <= ITER_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            iter_cap_ff <= csr_wr_data;
         end
         if (state_ff == ST_FINISH && out_free) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         cr_ff   <= req_tdata[COORD_W-1:0];
         ci_ff   <= req_tdata[2*COORD_W-1:COORD_W];
         zr_ff   <= req_tdata[COORD_W-1:0];
         zi_ff   <= req_tdata[2*COORD_W-1:COORD_W];
         iter_ff <= '0;
         hit_ff  <= 1'b0;
         rad_ff  <= '0;
         tre_ff  <= '0;
         tim_ff  <= '0;
      end
      if (state_ff == ST_SQ_IM) begin
         rsq_ff <= mul_q;
      end
      if (state_ff == ST_CROSS) begin
         isq_ff <= mul_q;
      end
      if (state_ff == ST_UPDATE) begin
         zr_ff <= zr_new;
         zi_ff <= zi_new;
         if (trap_now) begin
            hit_ff <= 1'b1;
            rad_ff <= mag[RAD_W-1:0];
            tre_ff <= zr_new;
            tim_ff <= zi_new;
         end
         if (!escape_now) begin
            iter_ff <= iter_ff + CNT_W'(1);
         end
      end
      if (state_ff == ST_FINISH && out_free) begin
         out_count_ff <= iter_ff;
         out_hit_ff   <= hit_ff;
         out_rad_ff   <= rad_ff;
         out_re_ff    <= tre_ff;
         out_im_ff    <= tim_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_hit_ff;
   assign rsp_tdata  = {(RSP_DATA_W - CNT_W - RAD_W - 2*COORD_W)'(0),
                        out_im_ff, out_re_ff, out_rad_ff, out_count_ff};

   `MOTP_ASSERT_IMP(a_busy_not_ready, clock, reset, state_ff != ST_IDLE, !req_tready)
   `MOTP_ASSERT_IMP(a_iter_in_bound, clock, reset,
                    state_ff != ST_IDLE && state_ff != ST_FINISH, iter_ff < bound)
   `MOTP_ASSERT_IMP(a_count_in_bound, clock, reset, out_valid_ff, out_count_ff <= bound)
   `MOTP_ASSERT_IMP(a_untrapped_zero, clock, reset, out_valid_ff && !out_hit_ff,
                    out_rad_ff == '0 && out_re_ff == '0 && out_im_ff == '0)
   `MOTP_ASSERT_NXT(a_update_to_finish, clock, reset,
                    state_ff == ST_UPDATE && last_iter, state_ff == ST_FINISH)

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Mandelbrot orbit trap point - testbench
// Streams Q4.28 points through the block and checks every result word
// (escape count, trap flag, trap radius and trap point) against an
// in-bench fixed-point orbit calculation. The iteration bound is moved
// between phases, including values below the minimum and above the limit.
// ----------------------------------------------------------------------------
module tb_top;
   import motp_pkg::*;

   localparam int  Q_ONE      = 1 << FRAC_BITS;
   localparam time RUN_LIMIT  = 64'd50_000_000;

   typedef struct packed {
      logic [CNT_W-1:0]   escape_count;
      logic               trapped;
      logic [RAD_W-1:0]   trap_radius_sq;
      logic [COORD_W-1:0] trap_re;
      logic [COORD_W-1:0] trap_im;
   } orbit_record_type;

   logic                  clock;
   logic                  reset       = 1'b1;
   logic                  csr_wr_en   = 1'b0;
   logic [CNT_W-1:0]      csr_wr_data = '0;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b1;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;

   orbit_record_type expected_orbits[$];
   logic [CNT_W-1:0] iter_bound_reg = ITER_RESET;
   int               mismatch_count = 0;
   bit               no_idle        = 1'b0;

   mandelbrot_orbit_trap_point uut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int draw_wait();
      return no_idle ? 0 : int'($urandom_range(0, 19));
   endfunction

   function automatic int effective_bound();
      int n;
      n = int'(iter_bound_reg);
      if (n > int'(ITER_LIMIT)) n = int'(ITER_LIMIT);
      if (n < int'(MIN_ITERS)) n = int'(MIN_ITERS);
      return n;
   endfunction

   function automatic longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // z <- z*z + c from z = c; floor-scaled products, strict compares
   function automatic orbit_record_type predict_orbit(logic signed [COORD_W-1:0] c_re,
                                                      logic signed [COORD_W-1:0] c_im);
      orbit_record_type rec;
      longint cr, ci, zr, zi, rsq, isq, xprod, mag;
      longint one_q, four_q;
      int     bound, step;
      bit     escaped;
      rec     = '0;
      one_q   = longint'(1) << FRAC_BITS;
      four_q  = longint'(4) << FRAC_BITS;
      cr      = longint'(c_re);
      ci      = longint'(c_im);
      zr      = cr;
      zi      = ci;
      bound   = effective_bound();
      step    = 0;
      escaped = 1'b0;
      while (step < bound && !escaped) begin
         rsq   = (zr * zr) >>> FRAC_BITS;
         isq   = (zi * zi) >>> FRAC_BITS;
         xprod = (zr * zi) >>> FRAC_BITS;
         mag   = rsq + isq;
         zr    = clip32(rsq - isq + cr);
         zi    = clip32(xprod + xprod + ci);
         if (mag < one_q) begin
            rec.trapped        = 1'b1;
            rec.trap_radius_sq = mag[RAD_W-1:0];
            rec.trap_re        = zr[COORD_W-1:0];
            rec.trap_im        = zi[COORD_W-1:0];
         end else if (mag > four_q) begin
            escaped = 1'b1;
         end
         if (!escaped) step++;
      end
      rec.escape_count = step[CNT_W-1:0];
      return rec;
   endfunction

   task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      $display("%0t ns: %s got %h, want %h", $time, field, got, want);
      mismatch_count++;
   endtask

   // result checker
   always @(posedge clock) begin
      orbit_record_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_orbits.size() == 0) begin
            report_mismatch("unexpected word", rsp_tdata[63:0], '0);
         end else begin
            want = expected_orbits.pop_front();
            if (rsp_tdata[12:0] !== want.escape_count)
               report_mismatch("escape_count", rsp_tdata[12:0], want.escape_count);
            if (rsp_tuser !== want.trapped)
               report_mismatch("trapped", rsp_tuser, want.trapped);
            if (rsp_tdata[40:13] !== want.trap_radius_sq)
               report_mismatch("trap_radius_sq", rsp_tdata[40:13], want.trap_radius_sq);
            if (rsp_tdata[72:41] !== want.trap_re)
               report_mismatch("trap_re", rsp_tdata[72:41], want.trap_re);
            if (rsp_tdata[104:73] !== want.trap_im)
               report_mismatch("trap_im", rsp_tdata[104:73], want.trap_im);
            if (rsp_tdata[111:105] !== '0)
               report_mismatch("pad bits", rsp_tdata[111:105], '0);
         end
      end
   end

   // result side back-pressure: hold off a random time before the next word
   initial begin
      int hold;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            hold = draw_wait();
            if (hold != 0) begin
               @(negedge clock);
               rsp_tready <= 1'b0;
               do @(posedge clock); while (!rsp_tvalid);
               repeat (hold) @(negedge clock);
               rsp_tready <= 1'b1;
            end
         end
      end
   end

   // all tasks below start and end just after a falling edge
   task automatic send_point(input logic signed [COORD_W-1:0] c_re,
                             input logic signed [COORD_W-1:0] c_im);
      int gap;
      gap = draw_wait();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  <= {c_im, c_re};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      expected_orbits.push_back(predict_orbit(c_re, c_im));
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_orbits.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic set_iter_bound(input logic [CNT_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      iter_bound_reg = value;
   endtask

   task automatic send_random_point();
      logic signed [COORD_W-1:0] re, im;
      case ($urandom_range(0, 9))
         0, 1: begin
            re = $urandom;
            im = $urandom;
         end
         2, 3, 4, 5: begin
            re = -(5 * Q_ONE / 2) + int'($urandom_range(7 * Q_ONE / 2, 0));
            im = -(3 * Q_ONE / 2) + int'($urandom_range(3 * Q_ONE, 0));
         end
         6, 7, 8: begin
            // near the main cardioid: long orbits, mostly trapped
            re = -(Q_ONE / 2) + int'($urandom_range(3 * Q_ONE / 4, 0));
            im = -(2 * Q_ONE / 5) + int'($urandom_range(4 * Q_ONE / 5, 0));
         end
         default: begin
            re = $signed($urandom) >>> $urandom_range(0, 31);
            im = $signed($urandom) >>> $urandom_range(0, 31);
         end
      endcase
      send_point(re, im);
   endtask

   task automatic test_directed_points();
      send_point(0, 0);
      send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      send_point(32'sh8000_0000, 32'sh8000_0000);
      send_point(32'sh7FFF_FFFF, 32'sh8000_0000);
      send_point(32'sh8000_0000, 32'sh7FFF_FFFF);
      send_point(-2 * Q_ONE, 0);                // magnitude stays exactly 4
      send_point(2 * Q_ONE, 0);                 // magnitude 4, then escapes
      send_point(Q_ONE, 0);                     // magnitude exactly 1
      send_point(Q_ONE - 1, 0);                 // just inside the trap
      send_point(-Q_ONE, 0);                    // period two orbit
      send_point(0, Q_ONE);
      send_point(Q_ONE / 4, 0);
      send_point(-(3 * Q_ONE / 4), Q_ONE / 10);
      send_point(-1, -1);                       // floor rounding of tiny values
      send_point(-1, 1);
      send_point(1, 1);
      send_point(-Q_ONE / 2, -Q_ONE / 2);
      wait_drained();
   endtask

   task automatic test_bound_below_min();
      set_iter_bound('0);
      send_point(0, 0);
      send_point(-2 * Q_ONE, 0);
      repeat (2) send_random_point();
      wait_drained();
   endtask

   task automatic test_bound_at_limit();
      set_iter_bound(ITER_LIMIT);
      send_point(0, 0);
      send_point(-2 * Q_ONE, 0);
      send_point(-(3 * Q_ONE / 4), Q_ONE / 10);
      wait_drained();
   endtask

   task automatic test_bound_above_limit();
      set_iter_bound({CNT_W{1'b1}});
      send_point(Q_ONE / 4, 0);
      send_point(-Q_ONE, 0);
      send_point(Q_ONE, Q_ONE);
      wait_drained();
   endtask

   task automatic test_random_points();
      for (int phase = 0; phase < 6; phase++) begin
         set_iter_bound(CNT_W'($urandom_range(300, 32)));
         no_idle = (phase == 2);
         repeat (19) send_random_point();
         wait_drained();
      end
      no_idle = 1'b0;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed_points();
      test_bound_below_min();
      test_bound_at_limit();
      test_bound_above_limit();
      test_random_points();
      repeat (4 * effective_bound() + 50) @(posedge clock);
      if (mismatch_count == 0 && expected_orbits.size() == 0)
         $display("mandelbrot_orbit_trap_point: match");
      else
         $display("mandelbrot_orbit_trap_point: mismatch");
      $finish;
   end

   initial begin
      #(RUN_LIMIT);
      $display("mandelbrot_orbit_trap_point: mismatch");
      $finish;
   end

endmodule
